// ===== rtl/rusi_pkg.sv =====
// ----------------------------------------------------------------------------
// rusi_pkg
// Shared constants for the ray / unit sphere intersection unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rusi_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  // Width of the multiplier digit consumed by one stage of a pipelined multiplier.
  localparam int MUL_DIGIT   = 16;

endpackage

// ===== rtl/rusi_mul.sv =====
// ----------------------------------------------------------------------------
// rusi_mul
// Pipelined unsigned multiplier: one digit of the second operand per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rusi_mul #(
  parameter int AW = rusi_pkg::COORD_WIDTH,
  parameter int BW = rusi_pkg::COORD_WIDTH,
  parameter int DW = rusi_pkg::MUL_DIGIT
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int NS  = (BW + DW - 1) / DW;
  localparam int BPW = NS * DW;
  localparam int PRW = AW + DW;
  localparam int ACW = AW + BPW;

  logic [AW-1:0]  ar  [NS];
  logic [BPW-1:0] br  [NS];
  logic [ACW-1:0] acc [NS];
  logic [BPW-1:0] bpad;

  assign bpad = BPW'(b);

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic [AW-1:0]  pa;
    logic [BPW-1:0] pb;
    logic [ACW-1:0] pacc;
    logic [PRW-1:0] prod;
    if (k == 0) begin : g_first
      assign pa   = a;
      assign pb   = bpad;
      assign pacc = '0;
    end else begin : g_next
      assign pa   = ar[k-1];
      assign pb   = br[k-1];
      assign pacc = acc[k-1];
    end
    assign prod = PRW'(pa) * PRW'(pb[DW-1:0]);
    always_ff @(posedge clk) begin
      if (en) begin
        ar[k]  <= pa;
        br[k]  <= pb >> DW;
        acc[k] <= pacc + (ACW'(prod) << (k * DW));
      end
    end
  end

  assign p = acc[NS-1][AW+BW-1:0];

endmodule

// ===== rtl/ray_unit_sphere_intersect_unit.sv =====
// ----------------------------------------------------------------------------
// ray_unit_sphere_intersect_unit
// Intersects a fixed-point ray with the unit sphere at the origin. The unit
// takes one ray per cycle while ray_stall is low. At the default widths a
// ray passes through 109 register stages: the input register, a two-stage
// and a four-stage multiplier section with the dot product and half b and c
// stages between them, the discriminant stage, 65 square root stages (one
// per root bit), the numerator stage, the divider set-up stage, 31 quotient
// stages and the output register. A ray that produces no hit gives no beat.
// A ray with two hits gives two beats and holds the pipeline while the second
// beat is sent; the only other stall comes from hit_stall, which holds the
// whole pipeline while a beat waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_unit_sphere_intersect_unit #(
  parameter int COORD_WIDTH = rusi_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = rusi_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ray_valid,
  output logic                          ray_stall,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] start_z,
  input  logic signed [COORD_WIDTH-1:0] dir_x,
  input  logic signed [COORD_WIDTH-1:0] dir_y,
  input  logic signed [COORD_WIDTH-1:0] dir_z,
  input  logic                          shadow_ray,
  output logic                          hit_valid,
  input  logic                          hit_stall,
  output logic signed [COORD_WIDTH-1:0] hit_distance,
  output logic                          shadow_hit,
  output logic                          last_hit
);

  localparam int W     = COORD_WIDTH;
  localparam int PW    = 2 * W;
  localparam int RW    = 2 * W + 1;
  localparam int SQW   = 2 * RW;
  localparam int RMW   = RW + 2;
  localparam int NW    = PW + 2;
  localparam int XW    = NW + FRAC_BITS;
  localparam int HW    = XW - (W - 1);
  localparam int CPW   = HW + PW;
  localparam int DVS   = W - 1;
  localparam int DW    = rusi_pkg::MUL_DIGIT;
  localparam int M1    = (W + DW - 1) / DW;
  localparam int M2    = (PW + DW - 1) / DW;
  localparam int DEPTH = 1 + M1 + 1 + 1 + M2 + 1 + RW + 1 + 1 + DVS;
  localparam logic [PW-1:0] ONE_SQ = PW'(1) << (2 * FRAC_BITS);

  logic adv;
  logic [DEPTH-1:0] vpipe;

  // Input register: magnitudes and signs.
  logic signed [W-1:0] st [3];
  logic signed [W-1:0] dr [3];
  logic [W-1:0] smag [3];
  logic [W-1:0] dmag [3];
  logic [2:0]   sgn;
  logic         shd0;

  assign st[0] = start_x;
  assign st[1] = start_y;
  assign st[2] = start_z;
  assign dr[0] = dir_x;
  assign dr[1] = dir_y;
  assign dr[2] = dir_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        smag[k] <= st[k][W-1] ? W'(-st[k]) : W'(st[k]);
        dmag[k] <= dr[k][W-1] ? W'(-dr[k]) : W'(dr[k]);
        sgn[k]  <= st[k][W-1] ^ dr[k][W-1];
      end
      shd0 <= shadow_ray;
    end
  end

  // First multiplier section.
  logic [PW-1:0] dd [3];
  logic [PW-1:0] ss [3];
  logic [PW-1:0] ds [3];

  for (genvar k = 0; k < 3; k++) begin : g_m1
    rusi_mul #(.AW(W), .BW(W), .DW(DW)) u_dd (
      .clk(clk), .en(adv), .a(dmag[k]), .b(dmag[k]), .p(dd[k]));
    rusi_mul #(.AW(W), .BW(W), .DW(DW)) u_ss (
      .clk(clk), .en(adv), .a(smag[k]), .b(smag[k]), .p(ss[k]));
    rusi_mul #(.AW(W), .BW(W), .DW(DW)) u_ds (
      .clk(clk), .en(adv), .a(dmag[k]), .b(smag[k]), .p(ds[k]));
  end

  logic [2:0] m1sgn [M1];
  logic       m1shd [M1];

  always_ff @(posedge clk) begin
    if (adv) begin
      m1sgn[0] <= sgn;
      m1shd[0] <= shd0;
      for (int k = 1; k < M1; k++) begin
        m1sgn[k] <= m1sgn[k-1];
        m1shd[k] <= m1shd[k-1];
      end
    end
  end

  // Dot products.
  logic [PW-1:0] sa, sss, sbp, sbm;
  logic          sshd;

  always_ff @(posedge clk) begin
    if (adv) begin
      sa   <= dd[0] + dd[1] + dd[2];
      sss  <= ss[0] + ss[1] + ss[2];
      sbp  <= (m1sgn[M1-1][0] ? '0 : ds[0]) + (m1sgn[M1-1][1] ? '0 : ds[1])
            + (m1sgn[M1-1][2] ? '0 : ds[2]);
      sbm  <= (m1sgn[M1-1][0] ? ds[0] : '0) + (m1sgn[M1-1][1] ? ds[1] : '0)
            + (m1sgn[M1-1][2] ? ds[2] : '0);
      sshd <= m1shd[M1-1];
    end
  end

  // Half b and c as magnitude and sign.
  logic [PW-1:0] ba, bmag, cmag;
  logic          bneg, cneg, bzer, bshd;

  always_ff @(posedge clk) begin
    if (adv) begin
      ba   <= sa;
      bneg <= sbp < sbm;
      bmag <= (sbp >= sbm) ? sbp - sbm : sbm - sbp;
      cneg <= sss < ONE_SQ;
      cmag <= (sss >= ONE_SQ) ? sss - ONE_SQ : ONE_SQ - sss;
      bzer <= sa == '0;
      bshd <= sshd;
    end
  end

  // Second multiplier section.
  logic [2*PW-1:0] b2, ac;

  rusi_mul #(.AW(PW), .BW(PW), .DW(DW)) u_b2 (
    .clk(clk), .en(adv), .a(bmag), .b(bmag), .p(b2));
  rusi_mul #(.AW(PW), .BW(PW), .DW(DW)) u_ac (
    .clk(clk), .en(adv), .a(ba), .b(cmag), .p(ac));

  logic [PW-1:0] m2a    [M2];
  logic [PW-1:0] m2bmag [M2];
  logic          m2bneg [M2];
  logic          m2cneg [M2];
  logic          m2kill [M2];
  logic          m2shd  [M2];

  always_ff @(posedge clk) begin
    if (adv) begin
      m2a[0]    <= ba;
      m2bmag[0] <= bmag;
      m2bneg[0] <= bneg;
      m2cneg[0] <= cneg;
      m2kill[0] <= bzer;
      m2shd[0]  <= bshd;
      for (int k = 1; k < M2; k++) begin
        m2a[k]    <= m2a[k-1];
        m2bmag[k] <= m2bmag[k-1];
        m2bneg[k] <= m2bneg[k-1];
        m2cneg[k] <= m2cneg[k-1];
        m2kill[k] <= m2kill[k-1];
        m2shd[k]  <= m2shd[k-1];
      end
    end
  end

  // Discriminant and square root, one root bit per stage.
  logic [SQW-1:0] sq_q    [RW+1];
  logic [RMW-1:0] sq_rem  [RW+1];
  logic [RW-1:0]  sq_root [RW+1];
  logic [PW-1:0]  sq_a    [RW+1];
  logic [PW-1:0]  sq_bmag [RW+1];
  logic           sq_bneg [RW+1];
  logic           sq_kill [RW+1];
  logic           sq_shd  [RW+1];

  logic [RMW-1:0] sq_rem_next  [RW+1];
  logic [RW-1:0]  sq_root_next [RW+1];

  always_comb begin
    logic [RMW+1:0] cat;
    logic [RMW+1:0] trial;
    sq_rem_next[0]  = '0;
    sq_root_next[0] = '0;
    for (int k = 1; k <= RW; k++) begin
      cat   = {sq_rem[k-1], sq_q[k-1][SQW-1:SQW-2]};
      trial = (RMW+2)'({sq_root[k-1], 2'b01});
      if (cat >= trial) begin
        sq_rem_next[k]  = RMW'(cat - trial);
        sq_root_next[k] = {sq_root[k-1][RW-2:0], 1'b1};
      end else begin
        sq_rem_next[k]  = RMW'(cat);
        sq_root_next[k] = {sq_root[k-1][RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_q[0]    <= m2cneg[M2-1] ? SQW'(b2) + SQW'(ac) : SQW'(b2) - SQW'(ac);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_a[0]    <= m2a[M2-1];
      sq_bmag[0] <= m2bmag[M2-1];
      sq_bneg[0] <= m2bneg[M2-1];
      sq_kill[0] <= m2kill[M2-1] || (!m2cneg[M2-1] && b2 < ac);
      sq_shd[0]  <= m2shd[M2-1];
      for (int k = 1; k <= RW; k++) begin
        sq_q[k]    <= sq_q[k-1] << 2;
        sq_rem[k]  <= sq_rem_next[k];
        sq_root[k] <= sq_root_next[k];
        sq_a[k]    <= sq_a[k-1];
        sq_bmag[k] <= sq_bmag[k-1];
        sq_bneg[k] <= sq_bneg[k-1];
        sq_kill[k] <= sq_kill[k-1];
        sq_shd[k]  <= sq_shd[k-1];
      end
    end
  end

  // Root numerators.
  logic [NW-1:0] n1, n2, na;
  logic          ng1, ng2, nkill, nshd;
  logic [NW-1:0] rx, bx, nsum, n1_next, n2_next;
  logic          ng1_next, ng2_next;

  always_comb begin
    rx   = NW'(sq_root[RW]);
    bx   = NW'(sq_bmag[RW]);
    nsum = bx + rx;
    if (!sq_bneg[RW]) begin
      n1_next  = (rx >= bx) ? rx - bx : bx - rx;
      ng1_next = rx < bx;
      n2_next  = nsum;
      ng2_next = nsum != '0;
    end else begin
      n1_next  = nsum;
      ng1_next = 1'b0;
      n2_next  = (bx >= rx) ? bx - rx : rx - bx;
      ng2_next = bx < rx;
    end
    if (n1_next == '0) ng1_next = 1'b0;
    if (n2_next == '0) ng2_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1    <= n1_next;
      n2    <= n2_next;
      ng1   <= ng1_next;
      ng2   <= ng2_next;
      na    <= NW'(sq_a[RW]);
      nkill <= sq_kill[RW] || (ng1_next && ng2_next);
      nshd  <= sq_shd[RW];
    end
  end

  // Two restoring dividers, one quotient bit per stage.
  logic [PW-1:0]  dv_rem [2][DVS+1];
  logic [W-2:0]   dv_xlo [2][DVS+1];
  logic [W-2:0]   dv_quo [2][DVS+1];
  logic           dv_ovf [2][DVS+1];
  logic [PW-1:0]  dv_a   [DVS+1];
  logic           dv_ok1 [DVS+1];
  logic           dv_ok2 [DVS+1];
  logic           dv_shd [DVS+1];
  logic           dv_none[DVS+1];

  logic [NW-1:0]  nl   [2];
  logic           ngl  [2];
  logic [XW-1:0]  xl   [2];
  logic           inl  [2];
  logic           ovl  [2];

  assign nl[0]  = n1;
  assign nl[1]  = n2;
  assign ngl[0] = ng1;
  assign ngl[1] = ng2;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      xl[l]  = XW'(nl[l]) << FRAC_BITS;
      ovl[l] = CPW'(xl[l][XW-1:W-1]) >= CPW'(na);
      inl[l] = !ngl[l] && nl[l] != '0 && nl[l] <= na;
    end
  end

  logic [PW-1:0] dv_rem_next [2][DVS+1];
  logic          dv_bit      [2][DVS+1];

  always_comb begin
    logic [PW:0] cat;
    for (int l = 0; l < 2; l++) begin
      dv_rem_next[l][0] = '0;
      dv_bit[l][0]      = 1'b0;
      for (int k = 1; k <= DVS; k++) begin
        cat = {dv_rem[l][k-1], dv_xlo[l][k-1][W-2]};
        if (cat >= (PW+1)'(dv_a[k-1])) begin
          dv_rem_next[l][k] = PW'(cat - (PW+1)'(dv_a[k-1]));
          dv_bit[l][k]      = 1'b1;
        end else begin
          dv_rem_next[l][k] = PW'(cat);
          dv_bit[l][k]      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        dv_rem[l][0] <= PW'(xl[l][XW-1:W-1]);
        dv_xlo[l][0] <= xl[l][W-2:0];
        dv_quo[l][0] <= '0;
        dv_ovf[l][0] <= ovl[l];
        for (int k = 1; k <= DVS; k++) begin
          dv_rem[l][k] <= dv_rem_next[l][k];
          dv_xlo[l][k] <= dv_xlo[l][k-1] << 1;
          dv_quo[l][k] <= {dv_quo[l][k-1][W-3:0], dv_bit[l][k]};
          dv_ovf[l][k] <= dv_ovf[l][k-1];
        end
      end
      dv_a[0]    <= PW'(na);
      dv_ok1[0]  <= !ng1;
      dv_ok2[0]  <= !ng2;
      dv_shd[0]  <= nshd;
      dv_none[0] <= nkill || (nshd && !(inl[0] || inl[1]));
      for (int k = 1; k <= DVS; k++) begin
        dv_a[k]    <= dv_a[k-1];
        dv_ok1[k]  <= dv_ok1[k-1];
        dv_ok2[k]  <= dv_ok2[k-1];
        dv_shd[k]  <= dv_shd[k-1];
        dv_none[k] <= dv_none[k-1];
      end
    end
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (adv) begin
      vpipe <= {vpipe[DEPTH-2:0], ray_valid};
    end
  end

  // Output register, holding up to two beats of one ray.
  logic [W-1:0] fd [2];
  logic         fin_load;
  logic [W-1:0] od1, od2;
  logic         ov, otwo, osh;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      fd[l] = dv_ovf[l][DVS] ? {1'b0, {(W-1){1'b1}}} : {1'b0, dv_quo[l][DVS]};
    end
  end

  assign fin_load  = vpipe[DEPTH-1] && !dv_none[DVS];
  assign adv       = !ov || (!hit_stall && !otwo);
  assign ray_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov   <= 1'b0;
      otwo <= 1'b0;
    end else if (adv) begin
      ov   <= fin_load;
      otwo <= fin_load && !dv_shd[DVS] && dv_ok1[DVS] && dv_ok2[DVS];
    end else if (!hit_stall) begin
      otwo <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fin_load) begin
        osh <= dv_shd[DVS];
        od2 <= fd[1];
        if (dv_shd[DVS]) begin
          od1 <= '0;
        end else if (dv_ok1[DVS]) begin
          od1 <= fd[0];
        end else begin
          od1 <= fd[1];
        end
      end
    end else if (!hit_stall) begin
      od1 <= od2;
    end
  end

  assign hit_valid    = ov;
  assign hit_distance = od1;
  assign shadow_hit   = osh;
  assign last_hit     = !otwo;

  a_two_needs_valid : assert property (@(posedge clk) disable iff (rst)
    otwo |-> ov) else $error("second beat pending without a valid beat");

  a_shadow_single : assert property (@(posedge clk) disable iff (rst)
    ov && osh |-> !otwo && od1 == '0) else $error("shadow beat malformed");

  a_second_drains : assert property (@(posedge clk) disable iff (rst)
    ov && otwo && !hit_stall |=> ov && !otwo) else $error("second beat lost");

  a_hold_on_stall : assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vpipe)) else $error("pipeline moved while held");

endmodule
